// ----- hw/rtl/bcdalu_pkg.sv -----
// bcdalu_pkg: transaction types, command codes and bcd constants
// for the accumulator arithmetic unit; no dependencies
package bcdalu_pkg;

  typedef enum logic [1:0] {
    CmdAdc = 2'd0,
    CmdSbc = 2'd1,
    CmdArr = 2'd2,
    CmdNop = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] acc_in;
    logic [7:0] operand;
    logic       carry_in;
    logic       decimal_mode;
  } in_t;

  typedef struct packed {
    logic [7:0] acc_out;
    logic       carry_out;
    logic       zero_flag;
    logic       negative_flag;
    logic       overflow_flag;
  } out_t;

  localparam logic [3:0] BcdDigitMax = 4'h9;
  localparam logic [3:0] BcdAdjust   = 4'h6;
  localparam logic [4:0] ArrFixLimit = 5'h05;

endpackage

// ----- hw/rtl/bcd_binary_alu_adc_sbc_arr.sv -----
// pipeline: a transaction passes the three register stages s1, s2 and s3 before its result is output
// throughput: one transaction per cycle; a stalled output backs up stage by stage
// reset: rst_ni asynchronous active low clears the stage valid bits only
// bcd_binary_alu_adc_sbc_arr: 8-bit adc/sbc/arr unit with nmos decimal flag rules
// depends on bcdalu_pkg
module bcd_binary_alu_adc_sbc_arr
  import bcdalu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  typedef struct packed {
    in_t        op;
    logic [8:0] sum;
    logic [8:0] diff;
    logic [4:0] adc_lo;
    logic [4:0] sbc_lo;
  } s1_t;

  typedef struct packed {
    in_t        op;
    logic [8:0] sum;
    logic [8:0] diff;
    logic [8:0] adc_r;
    logic [3:0] sbc_lo;
    logic [4:0] sbc_hi;
    out_t       arr_res;
  } s2_t;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  out_t s3_d, s3_q;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // stage 1: binary sum and difference, low nibble of the decimal forms
  logic [5:0] lo6;
  always_comb begin
    s1_d.op   = in_data_i;
    s1_d.sum  = {1'b0, in_data_i.acc_in} + {1'b0, in_data_i.operand}
              + 9'(in_data_i.carry_in);
    s1_d.diff = {1'b0, in_data_i.acc_in} - {1'b0, in_data_i.operand}
              - 9'(!in_data_i.carry_in);
    lo6 = {2'b0, in_data_i.acc_in[3:0]} + {2'b0, in_data_i.operand[3:0]}
        + 6'(in_data_i.carry_in);
    if (lo6 > {2'b0, BcdDigitMax}) begin
      lo6 = lo6 + {2'b0, BcdAdjust};
    end
    s1_d.adc_lo = {(lo6 > 6'h0f), lo6[3:0]};
    s1_d.sbc_lo = {1'b0, in_data_i.acc_in[3:0]} - {1'b0, in_data_i.operand[3:0]}
                - 5'(!in_data_i.carry_in);
  end

  // stage 2: decimal high part and the whole arr result
  logic [7:0] m;
  logic [7:0] r;
  logic       fix_lo, fix_hi;
  always_comb begin
    s2_d.op     = s1_q.op;
    s2_d.sum    = s1_q.sum;
    s2_d.diff   = s1_q.diff;
    s2_d.adc_r  = {5'b0, s1_q.adc_lo[3:0]}
                + {1'b0, s1_q.op.acc_in[7:4], 4'b0}
                + {1'b0, s1_q.op.operand[7:4], 4'b0}
                + (s1_q.adc_lo[4] ? 9'h010 : 9'h000);
    s2_d.sbc_lo = s1_q.sbc_lo[4] ? (s1_q.sbc_lo[3:0] - BcdAdjust) : s1_q.sbc_lo[3:0];
    s2_d.sbc_hi = {1'b0, s1_q.op.acc_in[7:4]} - {1'b0, s1_q.op.operand[7:4]}
                - 5'(s1_q.sbc_lo[4]);

    m      = s1_q.op.acc_in & s1_q.op.operand;
    r      = {s1_q.op.carry_in, m[7:1]};
    fix_lo = ({1'b0, m[3:0]} + {4'b0, m[0]}) > ArrFixLimit;
    fix_hi = ({1'b0, m[7:4]} + {4'b0, m[4]}) > ArrFixLimit;
    if (s1_q.op.decimal_mode) begin
      s2_d.arr_res.acc_out       = {fix_hi ? (r[7:4] + BcdAdjust) : r[7:4],
                                    fix_lo ? (r[3:0] + BcdAdjust) : r[3:0]};
      s2_d.arr_res.carry_out     = fix_hi;
      s2_d.arr_res.negative_flag = s1_q.op.carry_in;
      s2_d.arr_res.overflow_flag = r[6] ^ m[6];
    end else begin
      s2_d.arr_res.acc_out       = r;
      s2_d.arr_res.carry_out     = r[6];
      s2_d.arr_res.negative_flag = r[7];
      s2_d.arr_res.overflow_flag = r[6] ^ r[5];
    end
    s2_d.arr_res.zero_flag = (r == 8'h00);
  end

  // stage 3: decimal adc high adjust, flags and result select
  logic [9:0] adc_dec;
  logic [7:0] a, v;
  always_comb begin
    a       = s2_q.op.acc_in;
    v       = s2_q.op.operand;
    adc_dec = {1'b0, s2_q.adc_r}
            + ((s2_q.adc_r[8:4] > {1'b0, BcdDigitMax}) ? 10'h060 : 10'h000);
    unique case (s2_q.op.command)
      CmdAdc: begin
        s3_d.zero_flag = (s2_q.sum[7:0] == 8'h00);
        if (s2_q.op.decimal_mode) begin
          s3_d.acc_out       = adc_dec[7:0];
          s3_d.carry_out     = |adc_dec[9:8];
          s3_d.negative_flag = s2_q.adc_r[7];
          s3_d.overflow_flag = ~(a[7] ^ v[7]) & (a[7] ^ s2_q.adc_r[7]);
        end else begin
          s3_d.acc_out       = s2_q.sum[7:0];
          s3_d.carry_out     = s2_q.sum[8];
          s3_d.negative_flag = s2_q.sum[7];
          s3_d.overflow_flag = ~(a[7] ^ v[7]) & (a[7] ^ s2_q.sum[7]);
        end
      end
      CmdSbc: begin
        s3_d.zero_flag     = (s2_q.diff[7:0] == 8'h00);
        s3_d.carry_out     = !s2_q.diff[8];
        s3_d.negative_flag = s2_q.diff[7];
        s3_d.overflow_flag = (a[7] ^ v[7]) & (a[7] ^ s2_q.diff[7]);
        s3_d.acc_out       = s2_q.op.decimal_mode ?
            {(s2_q.sbc_hi[4] ? (s2_q.sbc_hi[3:0] - BcdAdjust) : s2_q.sbc_hi[3:0]),
             s2_q.sbc_lo} : s2_q.diff[7:0];
      end
      CmdArr: begin
        s3_d = s2_q.arr_res;
      end
      default: begin
        s3_d.acc_out       = a;
        s3_d.carry_out     = s2_q.op.carry_in;
        s3_d.zero_flag     = (a == 8'h00);
        s3_d.negative_flag = a[7];
        s3_d.overflow_flag = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q) s2_q <= s2_d;
    if (rdy3 && v2_q) s3_q <= s3_d;
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = s3_q;

endmodule

// ----- hw/rtl/bcdalu_chk.sv -----
// bcdalu_chk: port-level checks on transaction flow of the arithmetic unit
// depends on bcdalu_pkg; bound to bcd_binary_alu_adc_sbc_arr
module bcdalu_chk
  import bcdalu_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  logic [2:0] cnt_d, cnt_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q + 3'(in_acc) - 3'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // no result without an outstanding transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 3'd0)
    else $error("result without outstanding transaction");

  // never more in flight than register stages
  a_max_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd3)
    else $error("too many transactions in flight");

  // input backpressure only when the output is stalled
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind bcd_binary_alu_adc_sbc_arr bcdalu_chk u_bcdalu_chk (.*);
